>>> design/gdu_pkg.sv
`default_nettype none
package gdu_pkg;

    typedef enum logic [1:0] {
        FUNC_NEXT  = 2'd0,
        FUNC_PREV  = 2'd1,
        FUNC_DOY   = 2'd2,
        FUNC_DIFF  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  other_day;
        logic [3:0]  other_month;
        logic [13:0] other_year;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic [8:0]  day_of_year;
        logic [5:0]  week_number;
        logic [21:0] days_between;
        logic        out_of_range;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORD,
        ST_DIFF,
        ST_ABS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic ord_step;
        logic diff_step;
        logic abs_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_diff;
        logic ord_done;
        logic diff_done;
    } status_t;

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] q100;
        logic [6:0]  r100;
        q100 = 14'((y * 27'd5243) >> 19);
        r100 = 7'(y - 14'(q100 * 7'd100));
        is_leap = (y[1:0] == 2'd0) && ((r100 != 7'd0) || (q100[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        case (m)
            4'd2: days_in = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days_in = 5'd30;
            default: days_in = 5'd31;
        endcase
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] b;
        case (m)
            4'd1: b = 9'd0;
            4'd2: b = 9'd31;
            4'd3: b = 9'd59;
            4'd4: b = 9'd90;
            4'd5: b = 9'd120;
            4'd6: b = 9'd151;
            4'd7: b = 9'd181;
            4'd8: b = 9'd212;
            4'd9: b = 9'd243;
            4'd10: b = 9'd273;
            4'd11: b = 9'd304;
            default: b = 9'd334;
        endcase
        days_before = b + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
    endfunction

endpackage
`default_nettype wire

>>> design/gdu_ctrl.sv
`default_nettype none
module gdu_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output gdu_pkg::cmd_t         cmd,
    input  wire gdu_pkg::status_t stat
);
    import gdu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ORD;
                end
            end
            ST_ORD: begin
                cmd.ord_step = 1'b1;
                if (stat.ord_done) state_next = stat.is_diff ? ST_DIFF : ST_OUT;
            end
            ST_DIFF: begin
                cmd.diff_step = 1'b1;
                if (stat.diff_done) state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.abs_step = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> design/gdu_dp.sv
`default_nettype none
module gdu_dp (
    input  wire logic              aclk,
    input  wire gdu_pkg::in_item_t s_data,
    input  wire gdu_pkg::cmd_t     cmd,
    output gdu_pkg::status_t       stat,
    output gdu_pkg::out_item_t     m_data
);
    import gdu_pkg::*;

    logic [1:0]  func_reg;
    logic [4:0]  d1_reg, d2_reg;
    logic [3:0]  m1_reg, m2_reg;
    logic [13:0] y1_reg, y2_reg;
    logic        sub_reg;
    logic [1:0]  phase_reg;
    logic [8:0]  o1_reg, o2_reg;
    logic [13:0] ylo_reg, yhi_reg;
    logic [21:0] acc_reg;
    logic        done_reg;
    out_item_t   res_reg;

    logic [13:0] sy1, sy2;
    logic [3:0]  sm1, sm2;
    logic [4:0]  sd1, sd2, lim1, lim2;

    always_comb begin
        sy1 = (s_data.year == 14'd0) ? 14'd1 :
              (s_data.year > YEAR_MAX) ? YEAR_MAX : s_data.year;
        sy2 = (s_data.other_year == 14'd0) ? 14'd1 :
              (s_data.other_year > YEAR_MAX) ? YEAR_MAX : s_data.other_year;
        sm1 = (s_data.month == 4'd0) ? 4'd1 : (s_data.month > 4'd12) ? 4'd12 : s_data.month;
        sm2 = (s_data.other_month == 4'd0) ? 4'd1 :
              (s_data.other_month > 4'd12) ? 4'd12 : s_data.other_month;
        lim1 = days_in(sm1, is_leap(sy1));
        lim2 = days_in(sm2, is_leap(sy2));
        sd1 = (s_data.day == 5'd0) ? 5'd1 : (s_data.day > lim1) ? lim1 : s_data.day;
        sd2 = (s_data.other_day == 5'd0) ? 5'd1 :
              (s_data.other_day > lim2) ? lim2 : s_data.other_day;
    end

    logic [4:0]  dim;
    logic [4:0]  pdim;
    logic        leap1;
    logic [13:0] yc;
    logic [13:0] left;
    logic [13:0] step;
    logic [21:0] span;
    logic        big;

    always_comb begin
        leap1 = is_leap(y1_reg);
        dim   = days_in(m1_reg, leap1);
        pdim  = days_in(4'(m1_reg - 4'd1), leap1);
        yc    = phase_reg[0] ? y2_reg : y1_reg;
        left  = yhi_reg - ylo_reg;
        big   = (left >= 14'd400) && (ylo_reg[1:0] == 2'd0);
        step  = big ? 14'd400 : 14'd1;
        span  = big ? 22'd146097 : (is_leap(ylo_reg) ? 22'd366 : 22'd365);
    end

    assign stat = '{is_diff: (func_reg == FUNC_DIFF), ord_done: phase_reg[1],
                    diff_done: done_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_data.func;
            d1_reg    <= sd1;
            m1_reg    <= sm1;
            y1_reg    <= sy1;
            d2_reg    <= sd2;
            m2_reg    <= sm2;
            y2_reg    <= sy2;
            phase_reg <= 2'd0;
            res_reg   <= '0;
        end
        if (cmd.ord_step) begin
            if (phase_reg[0]) o2_reg <= days_before(m2_reg, is_leap(yc)) + 9'(d2_reg);
            else              o1_reg <= days_before(m1_reg, is_leap(yc)) + 9'(d1_reg);
            phase_reg <= phase_reg + 2'd1;
            if (phase_reg == 2'd1) begin
                sub_reg <= (y1_reg < y2_reg);
                ylo_reg <= (y1_reg < y2_reg) ? y1_reg : y2_reg;
                yhi_reg <= (y1_reg < y2_reg) ? y2_reg : y1_reg;
                acc_reg <= '0;
                done_reg <= (y1_reg == y2_reg);
            end
            if (phase_reg == 2'd1 && func_reg == FUNC_DOY) begin
                res_reg.day_of_year <= o1_reg;
                res_reg.week_number <= 6'((18'(o1_reg + 9'd6) * 18'd293) >> 11);
            end
            if (phase_reg == 2'd1 && func_reg == FUNC_NEXT) begin
                if (d1_reg < dim) begin
                    res_reg.result_day <= d1_reg + 5'd1;
                    res_reg.result_month <= m1_reg;
                    res_reg.result_year <= y1_reg;
                end else if (m1_reg < 4'd12) begin
                    res_reg.result_day <= 5'd1;
                    res_reg.result_month <= m1_reg + 4'd1;
                    res_reg.result_year <= y1_reg;
                end else if (y1_reg < YEAR_MAX) begin
                    res_reg.result_day <= 5'd1;
                    res_reg.result_month <= 4'd1;
                    res_reg.result_year <= y1_reg + 14'd1;
                end else begin
                    res_reg.result_day <= d1_reg;
                    res_reg.result_month <= m1_reg;
                    res_reg.result_year <= y1_reg;
                    res_reg.out_of_range <= 1'b1;
                end
            end
            if (phase_reg == 2'd1 && func_reg == FUNC_PREV) begin
                if (d1_reg > 5'd1) begin
                    res_reg.result_day <= d1_reg - 5'd1;
                    res_reg.result_month <= m1_reg;
                    res_reg.result_year <= y1_reg;
                end else if (m1_reg > 4'd1) begin
                    res_reg.result_day <= pdim;
                    res_reg.result_month <= m1_reg - 4'd1;
                    res_reg.result_year <= y1_reg;
                end else if (y1_reg > 14'd1) begin
                    res_reg.result_day <= 5'd31;
                    res_reg.result_month <= 4'd12;
                    res_reg.result_year <= y1_reg - 14'd1;
                end else begin
                    res_reg.result_day <= d1_reg;
                    res_reg.result_month <= m1_reg;
                    res_reg.result_year <= y1_reg;
                    res_reg.out_of_range <= 1'b1;
                end
            end
        end
        if (cmd.diff_step && !done_reg) begin
            acc_reg  <= acc_reg + span;
            ylo_reg  <= ylo_reg + step;
            done_reg <= (left == step);
        end
        if (cmd.abs_step) begin
            if (sub_reg) begin
                res_reg.days_between <= (acc_reg + 22'(o2_reg) >= 22'(o1_reg)) ?
                    acc_reg + 22'(o2_reg) - 22'(o1_reg) : 22'(o1_reg) - 22'(o2_reg) - acc_reg;
            end else begin
                res_reg.days_between <= (acc_reg + 22'(o1_reg) >= 22'(o2_reg)) ?
                    acc_reg + 22'(o1_reg) - 22'(o2_reg) : 22'(o2_reg) - 22'(o1_reg) - acc_reg;
            end
        end
    end

    assign m_data = res_reg;
endmodule
`default_nettype wire

>>> design/gregorian_date_unit.sv
// Gregorian date unit.
// s_ channel: one request per item (func, first date, second date).
// m_ channel: one result per request, held in an output register.
// Both channels use valid/ready; a transfer completes when both are high.
// Dates are clamped into 1..9999 / 1..12 / 1..month length on entry.
// Next day, previous day and day of year: after the request is accepted the
// controller runs ST_ORD to form the ordinal days, then raises m_valid in ST_OUT.
// Days between walks years from the lower to the upper year, 400 years per
// step while the lower year is a multiple of 4 and at least 400 years remain,
// else one year per step, one step per cycle, at most 425 steps across the
// full year range; m_valid rises in ST_OUT after the walk and the ST_ABS step.
// One request is in flight at a time; s_ready is high only when idle.
// If the receiver stalls, the result holds on m_ signals and no new request
// is taken until it is accepted.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any request in progress.
`default_nettype none
module gregorian_date_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gdu_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gdu_pkg::out_item_t      m_data
);
    import gdu_pkg::*;

    cmd_t    cmd;
    status_t stat;

    gdu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    gdu_dp u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .m_data (m_data)
    );
endmodule
`default_nettype wire
